// ----- design/sm83_pkg.sv -----
// sm83 alu package: operation codes, flag constants and the transaction payload types
// no dependencies; imported by the interfaces and every module of the block
package sm83_pkg;

	// operation codes
	localparam logic [4:0] FN_ADD   = 5'd0;
	localparam logic [4:0] FN_ADC   = 5'd1;
	localparam logic [4:0] FN_SUB   = 5'd2;
	localparam logic [4:0] FN_SBC   = 5'd3;
	localparam logic [4:0] FN_AND   = 5'd4;
	localparam logic [4:0] FN_OR    = 5'd5;
	localparam logic [4:0] FN_XOR   = 5'd6;
	localparam logic [4:0] FN_CP    = 5'd7;
	localparam logic [4:0] FN_INC   = 5'd8;
	localparam logic [4:0] FN_DEC   = 5'd9;
	localparam logic [4:0] FN_ADDHL = 5'd10;
	localparam logic [4:0] FN_ADDSP = 5'd11;
	localparam logic [4:0] FN_DAA   = 5'd12;
	localparam logic [4:0] FN_RLC   = 5'd13;
	localparam logic [4:0] FN_RRC   = 5'd14;
	localparam logic [4:0] FN_RL    = 5'd15;
	localparam logic [4:0] FN_RR    = 5'd16;
	localparam logic [4:0] FN_SLA   = 5'd17;
	localparam logic [4:0] FN_SRA   = 5'd18;
	localparam logic [4:0] FN_SWAP  = 5'd19;
	localparam logic [4:0] FN_SRL   = 5'd20;
	localparam logic [4:0] FN_BIT   = 5'd21;

	// decimal adjust, half carry and sign constants
	localparam logic [7:0]  DAA_LOW_ADJ  = 8'h06;
	localparam logic [7:0]  DAA_HIGH_ADJ = 8'h60;
	localparam logic [8:0]  DAA_HIGH_LIM = 9'h09F;
	localparam logic [3:0]  NIBBLE_MAX   = 4'hF;
	localparam logic [3:0]  BCD_DIGIT_MAX = 4'd9;
	localparam logic [11:0] HL_HALF_MASK = 12'hFFF;
	localparam logic [7:0]  SIGN_BIT     = 8'h80;

	typedef struct packed {
		logic [4:0]  func;
		logic [7:0]  acc;
		logic [7:0]  operand;
		logic [15:0] base_word;
		logic [15:0] addend_word;
		logic [2:0]  bit_index;
		logic        zero_in;
		logic        subtract_in;
		logic        half_in;
		logic        carry_in;
	} op_t;

	typedef struct packed {
		logic [7:0]  result_byte;
		logic [15:0] result_word;
		logic        zero_out;
		logic        subtract_out;
		logic        half_out;
		logic        carry_out;
	} res_t;

endpackage

// ----- design/sm83_op_if.sv -----
// operation channel: valid/ready handshake carrying one alu operation per transaction
// depends on sm83_pkg for op_t
interface sm83_op_if import sm83_pkg::*; ();
	logic valid;
	logic ready;
	op_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/sm83_res_if.sv -----
// result channel: valid/ready handshake carrying one alu result per transaction
// depends on sm83_pkg for res_t
interface sm83_res_if import sm83_pkg::*; ();
	logic valid;
	logic ready;
	res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/sm83_shifter.sv -----
// cb-prefixed rotates, shifts, swap and bit test on the byte operand
// depends on sm83_pkg
module sm83_shifter import sm83_pkg::*; (
	input  op_t  op,
	output res_t res
);
	logic [7:0] v;
	logic [7:0] r;
	logic       cout;

	assign v = op.operand;

	always_comb begin
		r    = v;
		cout = op.carry_in;
		unique case (op.func)
			FN_RLC:  begin r = {v[6:0], v[7]};         cout = v[7]; end
			FN_RRC:  begin r = {v[0], v[7:1]};         cout = v[0]; end
			FN_RL:   begin r = {v[6:0], op.carry_in};  cout = v[7]; end
			FN_RR:   begin r = {op.carry_in, v[7:1]};  cout = v[0]; end
			FN_SLA:  begin r = {v[6:0], 1'b0};         cout = v[7]; end
			FN_SRA:  begin r = {v[7], v[7:1]};         cout = v[0]; end
			FN_SWAP: begin r = {v[3:0], v[7:4]};       cout = 1'b0; end
			FN_SRL:  begin r = {1'b0, v[7:1]};         cout = v[0]; end
			default: begin r = v;                      cout = op.carry_in; end
		endcase
	end

	always_comb begin
		res.result_byte = r;
		res.result_word = 16'd0;
		if (op.func == FN_BIT) begin
			res.zero_out     = ~v[op.bit_index];
			res.subtract_out = 1'b0;
			res.half_out     = 1'b1;
			res.carry_out    = op.carry_in;
		end else begin
			res.zero_out     = (r == 8'd0);
			res.subtract_out = 1'b0;
			res.half_out     = 1'b0;
			res.carry_out    = cout;
		end
	end
endmodule

// ----- design/sm83_alu.sv -----
// single pass alu datapath: 8-bit arithmetic and logic, inc/dec, 16-bit adds, daa
// depends on sm83_pkg; instantiates sm83_shifter for the cb-prefixed group
module sm83_alu import sm83_pkg::*; (
	input  op_t  op,
	output res_t res
);
	res_t       shift_res;
	logic [7:0] a;
	logic [7:0] v;
	logic       cin;
	logic [8:0] sum9;
	logic [4:0] sum_lo;
	logic [8:0] dif9;
	logic [4:0] dif_lo;
	logic [7:0] inc8;
	logic [7:0] dec8;
	logic [16:0] hl17;
	logic [12:0] hl_lo;
	logic [15:0] sp16;
	logic [4:0] sp_lo;
	logic [8:0] sp_byte;
	logic [8:0] daa1;
	logic [8:0] daa2;
	logic [7:0] daa_r;
	logic       daa_c;

	sm83_shifter u_shift (
		.op  (op),
		.res (shift_res)
	);

	assign a   = op.acc;
	assign v   = op.operand;
	assign cin = ((op.func == FN_ADC) || (op.func == FN_SBC)) ? op.carry_in : 1'b0;

	assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, cin};
	assign sum_lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
	// bit 8 / bit 4 of the difference is the borrow
	assign dif9   = {1'b0, a} - {1'b0, v} - {8'd0, cin};
	assign dif_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};

	assign inc8 = v + 8'd1;
	assign dec8 = v - 8'd1;

	assign hl17  = {1'b0, op.base_word} + {1'b0, op.addend_word};
	assign hl_lo = {1'b0, op.base_word[11:0] & HL_HALF_MASK}
		+ {1'b0, op.addend_word[11:0] & HL_HALF_MASK};

	// signed offset for add sp, flags from the unsigned low byte
	assign sp16    = op.base_word + {{8{(v & SIGN_BIT) != 8'd0}}, v};
	assign sp_lo   = {1'b0, op.base_word[3:0]} + {1'b0, v[3:0]};
	assign sp_byte = {1'b0, op.base_word[7:0]} + {1'b0, v};

	// decimal adjust
	always_comb begin
		daa1  = {1'b0, a};
		daa2  = daa1;
		daa_c = op.carry_in;
		if (!op.subtract_in) begin
			if (op.half_in || (a[3:0] > BCD_DIGIT_MAX))
				daa1 = {1'b0, a} + {1'b0, DAA_LOW_ADJ};
			if (op.carry_in || (daa1 > DAA_HIGH_LIM))
				daa2 = daa1 + {1'b0, DAA_HIGH_ADJ};
			else
				daa2 = daa1;
			daa_c = op.carry_in | daa2[8];
		end else begin
			if (op.half_in)
				daa1 = {1'b0, a - DAA_LOW_ADJ};
			if (op.carry_in)
				daa2 = {1'b0, daa1[7:0] - DAA_HIGH_ADJ};
			else
				daa2 = daa1;
		end
		daa_r = daa2[7:0];
	end

	always_comb begin
		res.result_byte  = a;
		res.result_word  = 16'd0;
		res.zero_out     = op.zero_in;
		res.subtract_out = op.subtract_in;
		res.half_out     = op.half_in;
		res.carry_out    = op.carry_in;
		case (op.func) inside
			FN_ADD, FN_ADC: begin
				res.result_byte  = sum9[7:0];
				res.zero_out     = (sum9[7:0] == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = sum_lo[4];
				res.carry_out    = sum9[8];
			end
			FN_SUB, FN_SBC, FN_CP: begin
				res.result_byte  = (op.func == FN_CP) ? a : dif9[7:0];
				res.zero_out     = (dif9[7:0] == 8'd0);
				res.subtract_out = 1'b1;
				res.half_out     = dif_lo[4];
				res.carry_out    = dif9[8];
			end
			FN_AND: begin
				res.result_byte  = a & v;
				res.zero_out     = ((a & v) == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = 1'b1;
				res.carry_out    = 1'b0;
			end
			FN_OR: begin
				res.result_byte  = a | v;
				res.zero_out     = ((a | v) == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = 1'b0;
				res.carry_out    = 1'b0;
			end
			FN_XOR: begin
				res.result_byte  = a ^ v;
				res.zero_out     = ((a ^ v) == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = 1'b0;
				res.carry_out    = 1'b0;
			end
			FN_INC: begin
				res.result_byte  = inc8;
				res.zero_out     = (inc8 == 8'd0);
				res.subtract_out = 1'b0;
				res.half_out     = (v[3:0] == NIBBLE_MAX);
			end
			FN_DEC: begin
				res.result_byte  = dec8;
				res.zero_out     = (dec8 == 8'd0);
				res.subtract_out = 1'b1;
				res.half_out     = (v[3:0] == 4'd0);
			end
			FN_ADDHL: begin
				res.result_word  = hl17[15:0];
				res.subtract_out = 1'b0;
				res.half_out     = hl_lo[12];
				res.carry_out    = hl17[16];
			end
			FN_ADDSP: begin
				res.result_word  = sp16;
				res.zero_out     = 1'b0;
				res.subtract_out = 1'b0;
				res.half_out     = sp_lo[4];
				res.carry_out    = sp_byte[8];
			end
			FN_DAA: begin
				res.result_byte  = daa_r;
				res.zero_out     = (daa_r == 8'd0);
				res.half_out     = 1'b0;
				res.carry_out    = daa_c;
			end
			FN_RLC, FN_RRC, FN_RL, FN_RR, FN_SLA, FN_SRA, FN_SWAP, FN_SRL, FN_BIT: begin
				res = shift_res;
			end
			default: begin
				// unused codes: accumulator and flags pass through
			end
		endcase
	end
endmodule

// ----- design/sm83_alu_and_shifter_unit.sv -----
// sm83 alu and shifter, top level: operation register, single pass datapath, result register
// depends on sm83_pkg, sm83_op_if, sm83_res_if and sm83_alu
// flow: an accepted operation is registered in stage 1, then its result in stage 2, where
// it is offered; a result that is not taken stalls the pipeline
// throughput: one transaction per cycle if results are taken (two-stage register pipeline)
// reset: arst_n clears both stage valid flags at once; payload registers are not reset
module sm83_alu_and_shifter_unit import sm83_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sm83_op_if.sink   op,
	sm83_res_if.source result
);
	// stage 1 holds the accepted operation, stage 2 the finished result
	logic valid_s1;
	op_t  op_s1;
	logic valid_s2;
	res_t res_s2;
	res_t alu_res;
	logic advance;

	// pipeline moves when the result stage is empty or being taken this cycle
	assign advance  = !valid_s2 || result.ready;
	// a new transaction is taken whenever stage 1 is empty or moving on
	assign op.ready = !valid_s1 || advance;

	sm83_alu u_alu (
		.op  (op_s1),
		.res (alu_res)
	);

	// control: stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (op.ready)
				valid_s1 <= op.valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	// payload: captured only when its stage loads
	always_ff @(posedge clk) begin
		if (op.ready && op.valid)
			op_s1 <= op.payload;
		if (advance && valid_s1)
			res_s2 <= alu_res;
	end

	assign result.valid   = valid_s2;
	assign result.payload = res_s2;

	// an empty operation stage never refuses a transaction
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> op.ready)
		else $error("operation channel stalled with stage 1 empty");

	// an accepted operation is held in stage 1 on the next cycle
	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(op.valid && op.ready) |=> valid_s1)
		else $error("accepted operation lost before stage 1");

	// stage 1 drains into the result stage whenever the pipeline advances
	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> valid_s2)
		else $error("stage 1 operation lost on the way to the result stage");

	// a result that is not taken blocks stage 1 only when stage 1 is full
	a_stall_keeps_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stage 1 dropped its operation during a stall");
endmodule
